/* rtl/tcw_pkg.sv */
// Package for the text terminal cell writer: beat structs, control codes and
// the microcode table of the sequencer. Depends on nothing else.
`default_nettype none
package tcw_pkg;

  localparam int DefColumns   = 80;
  localparam int DefRows      = 25;
  localparam int DefTabSpaces = 4;

  localparam logic [7:0]  ChBackspace = 8'd8;
  localparam logic [7:0]  ChTab       = 8'd9;
  localparam logic [7:0]  ChNewline   = 8'd10;
  localparam logic [7:0]  ChVertTab   = 8'd11;
  localparam logic [7:0]  ChFormFeed  = 8'd12;
  localparam logic [7:0]  ChCarriage  = 8'd13;
  localparam logic [7:0]  ChSpace     = 8'h20;
  localparam logic [7:0]  AttrReset   = 8'h0F;
  localparam logic [15:0] CellReset   = {AttrReset, ChSpace};

  localparam logic OpPut  = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic RegTextAttribute = 1'b0;

  typedef struct packed {
    logic        op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_READ, ST_PRINT, ST_NL, ST_CONT, ST_BS0, ST_BS1,
    ST_CR, ST_FF, ST_BLANK, ST_SCR0, ST_SCR1, ST_DONE
  } step_e;

  typedef enum logic [2:0] {
    C_NONE, C_START, C_COL_LAST, C_ROW_LAST, C_REM_ZERO, C_HOME, C_PTR_LAST,
    C_PTR_SCR_END
  } cond_e;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_ADVANCE, CUR_NEWLINE, CUR_CR, CUR_HOME, CUR_BACK
  } cur_e;

  typedef enum logic [2:0] {
    W_NONE, W_CHAR, W_SPACE_CUR, W_BLANK_PTR, W_RESET_PTR, W_COPY_PTR
  } wr_e;

  typedef enum logic [1:0] {
    RD_NONE, RD_IDX, RD_SCROLL0, RD_SCROLL1
  } rd_e;

  typedef enum logic [1:0] {
    P_HOLD, P_CLEAR, P_INC
  } ptr_e;

  typedef struct packed {
    cond_e cond;
    step_e jump;
    step_e next;
    cur_e  cur;
    wr_e   wr;
    rd_e   rd;
    ptr_e  ptr;
    logic  rem_dec;
    logic  done;
  } ctrl_t;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = '{cond: C_NONE, jump: ST_IDLE, next: ST_IDLE, cur: CUR_HOLD, wr: W_NONE,
          rd: RD_NONE, ptr: P_HOLD, rem_dec: 1'b0, done: 1'b0};
    case (s)
      ST_CLR: begin
        c.wr = W_RESET_PTR; c.ptr = P_INC;
        c.cond = C_PTR_LAST; c.jump = ST_IDLE; c.next = ST_CLR;
      end
      ST_IDLE: begin
        c.cond = C_START;
      end
      ST_READ: begin
        c.rd = RD_IDX; c.next = ST_DONE;
      end
      ST_PRINT: begin
        c.wr = W_CHAR; c.cur = CUR_ADVANCE;
        c.cond = C_COL_LAST; c.jump = ST_NL; c.next = ST_CONT;
      end
      ST_NL: begin
        c.cur = CUR_NEWLINE; c.ptr = P_CLEAR;
        c.cond = C_ROW_LAST; c.jump = ST_SCR0; c.next = ST_CONT;
      end
      ST_CONT: begin
        c.rem_dec = 1'b1;
        c.cond = C_REM_ZERO; c.jump = ST_DONE; c.next = ST_PRINT;
      end
      ST_BS0: begin
        c.cur = CUR_BACK;
        c.cond = C_HOME; c.jump = ST_DONE; c.next = ST_BS1;
      end
      ST_BS1: begin
        c.wr = W_SPACE_CUR; c.next = ST_DONE;
      end
      ST_CR: begin
        c.cur = CUR_CR; c.next = ST_DONE;
      end
      ST_FF: begin
        c.cur = CUR_HOME; c.ptr = P_CLEAR; c.next = ST_BLANK;
      end
      ST_BLANK: begin
        c.wr = W_BLANK_PTR; c.ptr = P_INC;
        c.cond = C_PTR_LAST; c.jump = ST_CONT; c.next = ST_BLANK;
      end
      ST_SCR0: begin
        c.rd = RD_SCROLL0; c.next = ST_SCR1;
      end
      ST_SCR1: begin
        c.wr = W_COPY_PTR; c.rd = RD_SCROLL1; c.ptr = P_INC;
        c.cond = C_PTR_SCR_END; c.jump = ST_BLANK; c.next = ST_SCR1;
      end
      ST_DONE: begin
        c.done = 1'b1; c.next = ST_IDLE;
      end
      default: begin
        c.next = ST_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic step_e entry_step(logic op, logic [7:0] ch);
    step_e s;
    if (op == OpRead) begin
      s = ST_READ;
    end else begin
      case (ch)
        ChNewline, ChVertTab: s = ST_NL;
        ChCarriage:           s = ST_CR;
        ChFormFeed:           s = ST_FF;
        ChBackspace:          s = ST_BS0;
        default:              s = ST_PRINT;
      endcase
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/tcw_cell_ram.sv */
// Screen cell memory: one write port and one read port with registered data.
// Self-contained; used by text_terminal_cell_writer.
`default_nettype none
module tcw_cell_ram #(
  parameter int Depth = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [15:0]   rdata_o
);

  logic [15:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/text_terminal_cell_writer.sv */
// Top level of the text terminal cell writer: microcoded sequencer, cursor
// and sweep datapath, APB register. Depends on tcw_pkg and tcw_cell_ram.
//
// Channel   Direction  Handshake                      Payload
// item      in         start && !busy                 item_i (in_item_t)
// result    out        result_valid_o, one cycle      result_o (out_item_t)
// config    in         psel && penable && pwrite      pwdata, paddr, prdata
//
// A tab prints TAB_SPACES spaces; a backspace at home writes nothing, and a
// printable byte in the last column also wraps to the next line.
// A scroll sweeps the cell memory one cell per cycle through its single write
// port, and a form feed blanks every cell.
// After reset the memory is cleared while busy is high.
// The result strobe lasts one cycle; the receiver cannot stall, and a new beat
// is accepted while the previous result is shown.
`default_nettype none
module text_terminal_cell_writer #(
  parameter int COLUMNS    = tcw_pkg::DefColumns,
  parameter int ROWS       = tcw_pkg::DefRows,
  parameter int TAB_SPACES = tcw_pkg::DefTabSpaces
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire tcw_pkg::in_item_t item_i,
  output logic                   result_valid_o,
  output tcw_pkg::out_item_t     result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  import tcw_pkg::*;

  localparam int Cells = COLUMNS * ROWS;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  localparam logic [AW-1:0] LastCell  = AW'(Cells - 1);
  localparam logic [AW-1:0] ScrollEnd = AW'(Cells - COLUMNS - 1);
  localparam logic [CW-1:0] ColLast   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] RowLast   = RW'(ROWS - 1);
  localparam logic [TW-1:0] TabRem    = TW'(TAB_SPACES - 1);

  step_e         upc_q, upc_d;
  ctrl_t         ctrl;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [TW-1:0] rem_q, rem_d;
  logic [7:0]    ch_q, ch_d;
  logic          is_read_q, is_read_d;
  logic          rd_ok_q, rd_ok_d;
  logic [10:0]   idx_q, idx_d;
  logic [7:0]    attr_q, attr_d;
  logic          valid_q, valid_d;
  out_item_t     res_q, res_d;

  logic          accept;
  logic          cond_hit;
  logic [AW-1:0] cur_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW:0]   rd_wide;
  logic [15:0]   ram_rdata;
  logic          cfg_wr;

  assign ctrl     = ucode(upc_q);
  assign accept   = start && !busy;
  assign busy     = (upc_q != ST_IDLE);
  assign cur_addr = AW'(32'(row_q) * COLUMNS + 32'(col_q));

  always_comb begin
    case (ctrl.cond)
      C_START:       cond_hit = start;
      C_COL_LAST:    cond_hit = (col_q == ColLast);
      C_ROW_LAST:    cond_hit = (row_q == RowLast);
      C_REM_ZERO:    cond_hit = (rem_q == '0);
      C_HOME:        cond_hit = (col_q == '0) && (row_q == '0);
      C_PTR_LAST:    cond_hit = (ptr_q == LastCell);
      C_PTR_SCR_END: cond_hit = (ptr_q == ScrollEnd);
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (ctrl.cond == C_START) begin
      upc_d = start ? entry_step(item_i.op, item_i.char_code) : ST_IDLE;
    end else if (cond_hit) begin
      upc_d = ctrl.jump;
    end else begin
      upc_d = ctrl.next;
    end
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    ch_d      = ch_q;
    is_read_d = is_read_q;
    rd_ok_d   = rd_ok_q;
    idx_d     = idx_q;
    valid_d   = 1'b0;
    res_d     = res_q;

    if (accept) begin
      is_read_d = (item_i.op == OpRead);
      rd_ok_d   = (32'(item_i.cell_index) < Cells);
      idx_d     = item_i.cell_index;
      ch_d      = (item_i.char_code == ChTab) ? ChSpace : item_i.char_code;
      rem_d     = (item_i.op == OpPut && item_i.char_code == ChTab) ? TabRem : '0;
    end

    case (ctrl.cur)
      CUR_ADVANCE: begin
        if (col_q != ColLast) begin
          col_d = col_q + 1'b1;
        end
      end
      CUR_NEWLINE: begin
        col_d = '0;
        if (row_q != RowLast) begin
          row_d = row_q + 1'b1;
        end
      end
      CUR_CR: begin
        col_d = '0;
      end
      CUR_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      CUR_BACK: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end else if (row_q != '0) begin
          row_d = row_q - 1'b1;
          col_d = ColLast;
        end
      end
      default: begin
      end
    endcase

    case (ctrl.ptr)
      P_CLEAR: ptr_d = '0;
      P_INC:   ptr_d = ptr_q + 1'b1;
      default: begin
      end
    endcase

    if (ctrl.rem_dec && rem_q != '0) begin
      rem_d = rem_q - 1'b1;
    end

    if (ctrl.done) begin
      valid_d             = 1'b1;
      res_d.read_data     = (is_read_q && rd_ok_q) ? ram_rdata : 16'h0000;
      res_d.cursor_column = 7'(col_q);
      res_d.cursor_row    = 5'(row_q);
    end
  end

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = ptr_q;
    ram_wdata = {attr_q, ChSpace};
    case (ctrl.wr)
      W_CHAR: begin
        ram_waddr = cur_addr;
        ram_wdata = {attr_q, ch_q};
      end
      W_SPACE_CUR: ram_waddr = cur_addr;
      W_BLANK_PTR: ram_wdata = {attr_q, ChSpace};
      W_RESET_PTR: ram_wdata = CellReset;
      W_COPY_PTR:  ram_wdata = ram_rdata;
      default:     ram_we = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.rd)
      RD_IDX:     rd_wide = (AW + 1)'(idx_q);
      RD_SCROLL0: rd_wide = (AW + 1)'(32'(ptr_q) + COLUMNS);
      RD_SCROLL1: rd_wide = (AW + 1)'(32'(ptr_q) + COLUMNS + 1);
      default:    rd_wide = '0;
    endcase
    ram_re = (ctrl.rd != RD_NONE) && (32'(rd_wide) < Cells);
  end

  tcw_cell_ram #(
    .Depth(Cells),
    .AW   (AW)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_wide[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign attr_d = (cfg_wr && paddr[2] == RegTextAttribute) ? pwdata[7:0] : attr_q;
  assign prdata = (paddr[2] == RegTextAttribute) ? {24'h000000, attr_q} : 32'h00000000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= ST_CLR;
      col_q   <= '0;
      row_q   <= '0;
      ptr_q   <= '0;
      rem_q   <= '0;
      attr_q  <= AttrReset;
      valid_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ptr_q   <= ptr_d;
      rem_q   <= rem_d;
      attr_q  <= attr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    is_read_q <= is_read_d;
    rd_ok_q   <= rd_ok_d;
    idx_q     <= idx_d;
    res_q     <= res_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == ST_DONE) |=> result_valid_o)
    else $error("result strobe missing after the done step");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted beat did not start the sequencer");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= ColLast) && (row_q <= RowLast))
    else $error("cursor outside the screen");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == ST_IDLE) |-> !ram_we)
    else $error("cell write while idle");

  a_put_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.read_data != 16'h0000) |-> $past(is_read_q))
    else $error("put beat returned nonzero read data");

endmodule
`default_nettype wire

/* tb/tcw_checker.sv */
// Checker for the text terminal cell writer: watches the item, result and APB
// channels, keeps its own copy of the screen and cursor, and compares results.
// Depends on tcw_pkg.
`timescale 1ns / 100ps
module tcw_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  tcw_pkg::in_item_t  item_i,
  input  logic               res_valid_i,
  input  tcw_pkg::out_item_t res_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 scrolls_o,
  output int                 clears_o
);
  import tcw_pkg::*;

  localparam int Cols  = DefColumns;
  localparam int Rows  = DefRows;
  localparam int Cells = Cols * Rows;
  localparam logic [2:0] AttrAddr = 3'(4 * int'(RegTextAttribute));

  logic [15:0] screen_q [Cells];
  logic [6:0]  col_q;
  logic [4:0]  row_q;
  logic [7:0]  attr_q;
  out_item_t   awaited_q [$];

  task automatic blank_row(input int r);
    for (int x = 0; x < Cols; x++) begin
      screen_q[r * Cols + x] = {attr_q, ChSpace};
    end
  endtask

  task automatic scroll_up();
    for (int i = 0; i + Cols < Cells; i++) begin
      screen_q[i] = screen_q[i + Cols];
    end
    blank_row(Rows - 1);
    row_q = 5'(Rows - 1);
    scrolls_o++;
  endtask

  task automatic next_line();
    col_q = '0;
    if (int'(row_q) >= Rows - 1) begin
      scroll_up();
    end else begin
      row_q++;
    end
  endtask

  task automatic print_char(input logic [7:0] ch);
    screen_q[int'(row_q) * Cols + int'(col_q)] = {attr_q, ch};
    if (int'(col_q) >= Cols - 1) begin
      next_line();
    end else begin
      col_q++;
    end
  endtask

  task automatic put_char(input logic [7:0] ch);
    case (ch)
      ChNewline, ChVertTab: begin
        next_line();
      end
      ChCarriage: begin
        col_q = '0;
      end
      ChFormFeed: begin
        for (int r = 0; r < Rows; r++) begin
          blank_row(r);
        end
        col_q = '0;
        row_q = '0;
        clears_o++;
      end
      ChBackspace: begin
        if (col_q != '0) begin
          col_q--;
          screen_q[int'(row_q) * Cols + int'(col_q)] = {attr_q, ChSpace};
        end else if (row_q != '0) begin
          row_q--;
          col_q = 7'(Cols - 1);
          screen_q[int'(row_q) * Cols + int'(col_q)] = {attr_q, ChSpace};
        end
      end
      ChTab: begin
        for (int i = 0; i < DefTabSpaces; i++) begin
          print_char(ChSpace);
        end
      end
      default: begin
        print_char(ch);
      end
    endcase
  endtask

  task automatic predict_cell(input in_item_t it, output out_item_t r);
    r = '0;
    if (it.op == OpPut) begin
      put_char(it.char_code);
    end else if (int'(it.cell_index) < Cells) begin
      r.read_data = screen_q[it.cell_index];
    end
    r.cursor_column = col_q;
    r.cursor_row    = row_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Cells; i++) begin
        screen_q[i] = CellReset;
      end
      col_q        = '0;
      row_q        = '0;
      attr_q       = AttrReset;
      awaited_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      scrolls_o    = 0;
      clears_o     = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == AttrAddr) begin
        attr_q = pwdata_i[7:0];
      end
      if (res_valid_i) begin
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result beat with nothing awaited: data %h col %0d row %0d",
                     $time, res_i.read_data, res_i.cursor_column, res_i.cursor_row);
          end
        end else begin
          want = awaited_q.pop_front();
          checked_o++;
          if (res_i.read_data !== want.read_data ||
              res_i.cursor_column !== want.cursor_column ||
              res_i.cursor_row !== want.cursor_row) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch: expected data %h col %0d row %0d, got data %h col %0d row %0d",
                       $time, want.read_data, want.cursor_column, want.cursor_row,
                       res_i.read_data, res_i.cursor_column, res_i.cursor_row);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_cell(item_i, want);
        awaited_q.push_back(want);
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the text terminal cell writer testbench: clock, reset, item and APB
// stimulus, and the verdict. Depends on tcw_pkg, the block and tcw_checker.
`timescale 1ns / 100ps
module tb_top;
  import tcw_pkg::*;

  localparam int ItemsPerPhase = 60;
  localparam int Phases        = 5;
  localparam int LimitNs       = 40_000_000;
  localparam logic [2:0] AttrAddr = 3'(4 * int'(RegTextAttribute));

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  in_item_t    beat    = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        result_valid;
  out_item_t   result;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, checked, scrolls, clears;
  int n_puts = 0;
  int n_reads = 0;
  int n_settings = 0;
  bit gapless = 1'b1;

  always #5 clk_i = ~clk_i;

  text_terminal_cell_writer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (beat),
    .result_valid_o(result_valid),
    .result_o      (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tcw_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (beat),
    .res_valid_i (result_valid),
    .res_i       (result),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .scrolls_o   (scrolls),
    .clears_o    (clears)
  );

  function automatic in_item_t put_beat(input logic [7:0] ch);
    in_item_t b;
    b.op         = OpPut;
    b.char_code  = ch;
    b.cell_index = 11'($urandom);
    return b;
  endfunction

  function automatic in_item_t read_beat(input int idx);
    in_item_t b;
    b.op         = OpRead;
    b.char_code  = 8'($urandom);
    b.cell_index = 11'(idx);
    return b;
  endfunction

  function automatic logic [7:0] printable();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (ch >= ChBackspace && ch <= ChCarriage) begin
      ch = 8'($urandom_range(0, 255));
    end
    return ch;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send(input in_item_t b);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    beat  <= b;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (b.op == OpPut) begin
      n_puts++;
    end else begin
      n_reads++;
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_attr(input logic [7:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AttrAddr;
    pwdata  <= {24'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  task automatic run_burst();
    int sel, len, n, k;
    logic [7:0] ctl [5];
    ctl = '{ChBackspace, ChTab, ChNewline, ChVertTab, ChCarriage};
    sel = $urandom_range(0, 99);
    gapless = ($urandom_range(0, 2) == 0);
    if (sel < 55) begin
      // A line of text, sometimes long enough to wrap, then an end-of-line code.
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(76, 86) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        k = $urandom_range(0, 19);
        if (k == 0) begin
          send(put_beat(ChTab));
        end else if (k == 1) begin
          send(put_beat(ChBackspace));
        end else begin
          send(put_beat(printable()));
        end
      end
      k = $urandom_range(0, 5);
      send(put_beat(k == 0 ? ChCarriage : (k == 1 ? ChVertTab : ChNewline)));
    end else if (sel < 70) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          send(put_beat(ChFormFeed));
        end else begin
          send(put_beat(ctl[$urandom_range(0, 4)]));
        end
      end
    end else if (sel < 92) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 5);
        case (k)
          0:       send(read_beat($urandom_range(1920, 1999)));
          1:       send(read_beat($urandom_range(2000, 2047)));
          2:       send(read_beat($urandom_range(0, 79)));
          default: send(read_beat($urandom_range(0, 1999)));
        endcase
      end
    end else begin
      send(in_item_t'($urandom));
    end
  endtask

  initial begin : stimulus
    int mark;
    logic [7:0] attr;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    gapless = 1'b1;
    send(read_beat(0));
    send(read_beat(1999));
    send(read_beat(2000));
    send(read_beat(2047));
    send(put_beat(ChBackspace));
    send(put_beat(8'h00));
    send(put_beat(8'hFF));
    send(put_beat(8'h41));
    send(put_beat(ChTab));
    send(put_beat(ChCarriage));
    send(put_beat(ChNewline));
    send(put_beat(ChBackspace));
    send(read_beat(79));
    send(put_beat(ChVertTab));
    send(put_beat(8'h7F));
    send(read_beat(0));
    send(read_beat(1));
    send(put_beat(ChFormFeed));
    send(read_beat(0));
    send(read_beat(1999));

    for (int p = 0; p < Phases; p++) begin
      wait_quiet();
      case (p)
        0:       attr = 8'hFF;
        1:       attr = 8'h00;
        4:       attr = AttrReset;
        default: attr = 8'($urandom);
      endcase
      write_attr(attr);
      mark = n_puts + n_reads;
      while (n_puts + n_reads - mark < ItemsPerPhase) begin
        run_burst();
      end
    end

    wait_quiet();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d beats (%0d puts, %0d reads) over %0d attribute settings; %0d results checked.",
             n_puts + n_reads, n_puts, n_reads, n_settings, checked);
    $display("The screen scrolled %0d times and was cleared %0d times.", scrolls, clears);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitNs);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
